// File: hw/rtl/bdpc_pkg.sv
`default_nettype none

package bdpc_pkg;

  // Configuration register file
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 1'd1;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_DATA_W-1:0] HOLD_RESET     = 16'd750;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Press event codes
  localparam int unsigned EV_W = 2;

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_PUSH  = 2'd1;
  localparam logic [EV_W-1:0] EV_QUICK = 2'd2;
  localparam logic [EV_W-1:0] EV_HOLD  = 2'd3;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ticks;
    logic [CFG_DATA_W-1:0] hold_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/bdpc_if.sv
`default_nettype none

interface bdpc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface bdpc_out_if;
  logic                     valid;
  logic                     ready;
  logic [bdpc_pkg::EV_W-1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink (input valid, input press_event, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/button_debounce_press_classifier_unit.sv
// Button debouncer with quick/hold press classification, one button per instance.
//
// in_ch carries one sampled button level per tick (1 = pressed); every accepted
// beat produces exactly one beat on out_ch with a press_event code:
// none, stable pressed, quick press released or hold press released.
// cfg_we/cfg_index/cfg_wdata write debounce_ticks (index 0) and hold_ticks
// (index 1); write them only while no beat is in flight.
//
// The settle/press counters, latch and event code are computed combinationally
// from the incoming beat in one pass and the code lands in the output register
// at the accepting edge. Throughput is one beat per cycle while the receiver
// takes results, bounded by the single output register.
// in_ch.ready stays high while the output register is empty or being taken
// in the same cycle; when the receiver stalls, the result holds and input
// is back-pressured.
// Synchronous reset (rst_n low) clears the counters, the pressed latch, the
// last level (released) and the output valid, and loads debounce_ticks = 50
// and hold_ticks = 750.
`default_nettype none

module button_debounce_press_classifier_unit #(
  parameter int unsigned COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bdpc_in_if.sink                                in_ch,
  bdpc_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bdpc_pkg::*;

  cfg_t            cfg_r;
  logic            out_valid_r;
  logic [EV_W-1:0] out_event_r;
  logic [EV_W-1:0] event_code;
  logic            in_ready;
  logic            step;

  assign in_ready     = !out_valid_r || out_ch.ready;
  assign step         = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.press_event = out_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RESET;
      cfg_r.hold_ticks     <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_wdata;
        REG_HOLD:     cfg_r.hold_ticks     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bdpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .level      (in_ch.button_level),
    .cfg        (cfg_r),
    .event_code (event_code)
  );

  // Load a fresh result on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event_r <= event_code;
    end
  end

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> out_ch.valid)
    else $error("accepted beat produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while a stalled result is pending");

  a_result_matches_core: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_ch.press_event == $past(event_code))
    else $error("output register lost the computed event");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bdpc_core.sv
`default_nettype none

module bdpc_core #(
  parameter int unsigned COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic                          level,
  input  wire bdpc_pkg::cfg_t                cfg,
  output logic [bdpc_pkg::EV_W-1:0]          event_code
);
  import bdpc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

  logic                   last_level_r;
  logic                   last_level_nxt;
  logic [COUNT_WIDTH-1:0] settle_count_r;
  logic [COUNT_WIDTH-1:0] settle_count_nxt;
  logic [COUNT_WIDTH-1:0] press_count_r;
  logic [COUNT_WIDTH-1:0] press_count_nxt;
  logic                   latch_r;
  logic                   latch_nxt;

  logic [COUNT_WIDTH-1:0] press_sat;
  logic                   stable;

  always_comb begin
    press_sat = (press_count_r == {COUNT_WIDTH{1'b1}}) ? press_count_r
                : press_count_r + COUNT_WIDTH'(1);

    // A level change restarts the settle timer; otherwise advance, saturating
    if (level != last_level_r) begin
      settle_count_nxt = '0;
    end else if (settle_count_r == {COUNT_WIDTH{1'b1}}) begin
      settle_count_nxt = settle_count_r;
    end else begin
      settle_count_nxt = settle_count_r + COUNT_WIDTH'(1);
    end

    stable = CMP_W'(settle_count_nxt) >= CMP_W'(cfg.debounce_ticks);

    press_count_nxt = press_sat;
    latch_nxt       = latch_r;
    last_level_nxt  = level;
    event_code      = EV_NONE;

    if (stable && level) begin
      if (!latch_r) begin
        press_count_nxt = '0;
        latch_nxt       = 1'b1;
      end
      event_code = EV_PUSH;
    end else if (stable && latch_r) begin
      event_code = (CMP_W'(press_sat) >= CMP_W'(cfg.hold_ticks)) ? EV_HOLD : EV_QUICK;
      latch_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b0;
      settle_count_r <= '0;
      press_count_r  <= '0;
      latch_r        <= 1'b0;
    end else if (step) begin
      last_level_r   <= last_level_nxt;
      settle_count_r <= settle_count_nxt;
      press_count_r  <= press_count_nxt;
      latch_r        <= latch_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_release_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    step && (event_code == EV_QUICK || event_code == EV_HOLD) |-> latch_r)
    else $error("release reported without a latched press");

  a_release_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
    step && (event_code == EV_QUICK || event_code == EV_HOLD) |=> !latch_r)
    else $error("latch not cleared after release");

  a_push_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
    step && event_code == EV_PUSH |=> latch_r && last_level_r)
    else $error("latch not set after stable press");
`endif

endmodule

`default_nettype wire
